### rtl/core/sorted_list_union_merge_unit_macros.svh
// assertion macros shared by the merge unit rtl
`ifndef SORTED_LIST_UNION_MERGE_UNIT_MACROS_SVH
`define SORTED_LIST_UNION_MERGE_UNIT_MACROS_SVH

// condition must hold in the same cycle
`define SLUM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the next cycle
`define SLUM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/slum_pkg.sv
// shared types and constants of the sorted list union merge unit
package slum_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_WIDTH       = 2;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_MERGE  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMPTY
    } t_state;

endpackage

### rtl/core/slum_ifs.sv
// request and result channel interfaces of the merge unit
interface slum_req_if import slum_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic        [OP_WIDTH-1:0]   op;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface slum_res_if import slum_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value_res;
    logic                         last;
    logic                         empty_res;
    logic                         overflowed;

    modport source (output valid, output value_res, output last, output empty_res,
                    output overflowed, input ready);
    modport sink   (input valid, input value_res, input last, input empty_res,
                    input overflowed, output ready);
endinterface

### rtl/core/sorted_list_union_merge_unit.sv
// sorted list union merge unit: two list stores, two-pointer merge with dedup
//
//  channel  dir  payload                                   handshake
//  i_req    in   op, value                                 valid / ready
//  o_res    out  value_res, last, empty_res, overflowed    valid / ready
//
// a load is accepted whenever no merge is running.
// a merge walks both stores at one element per cycle while the result register is free,
// bounded by the single read port of each store.
// a stalled result register holds the walk; no request is taken until the merge ends.
// synchronous active-low reset clears counts, pointers and flags; stores need no clear.
`include "sorted_list_union_merge_unit_macros.svh"

module sorted_list_union_merge_unit import slum_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slum_req_if.sink     i_req,
    slum_res_if.source   o_res
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0]         r_idx_a, n_idx_a, r_idx_b, n_idx_b;
    logic                  r_ovf, n_ovf;
    logic [DATA_WIDTH-1:0] r_pend, n_pend;
    logic                  r_pend_vld, n_pend_vld;
    logic                  r_out_vld;
    logic [DATA_WIDTH-1:0] r_out_val;
    logic                  r_out_last, r_out_empty, r_out_ovf;

    logic [DATA_WIDTH-1:0] head_a, head_b, pick;
    logic                  req_acc, is_load_a, is_load_b, is_merge;
    logic                  we_a, we_b;
    logic                  a_avail, b_avail, walk_done, take_a;
    logic                  slot_free, step, finish, push;

    slum_list_ram #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (i_req.value),
        .i_raddr (n_idx_a[AW-1:0]),
        .o_rdata (head_a)
    );

    slum_list_ram #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (i_req.value),
        .i_raddr (n_idx_b[AW-1:0]),
        .o_rdata (head_b)
    );

    // request decode
    always_comb begin
        is_load_a = 1'b0;
        is_load_b = 1'b0;
        is_merge  = 1'b0;
        case (t_op'(i_req.op))
            OP_LOAD_A: is_load_a = 1'b1;
            OP_LOAD_B: is_load_b = 1'b1;
            OP_MERGE:  is_merge  = 1'b1;
            default: ;
        endcase
    end

    assign req_acc = i_req.valid && i_req.ready;
    assign we_a    = req_acc && is_load_a && (r_cnt_a < FULL);
    assign we_b    = req_acc && is_load_b && (r_cnt_b < FULL);

    // merge datapath: heads come from the reads issued last cycle
    assign a_avail   = r_idx_a < r_cnt_a;
    assign b_avail   = r_idx_b < r_cnt_b;
    assign walk_done = !a_avail && !b_avail;
    assign take_a    = a_avail && (!b_avail || ($signed(head_a) <= $signed(head_b)));
    assign pick      = take_a ? head_a : head_b;
    assign slot_free = !r_out_vld || o_res.ready;
    assign step      = (r_state == ST_WALK) && !walk_done && slot_free;
    assign finish    = slot_free && (((r_state == ST_WALK) && walk_done)
                                     || (r_state == ST_EMPTY));
    // pending element leaves once a differing element shows up or the merge finishes
    assign push      = finish || (step && r_pend_vld && (pick != r_pend));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_acc && is_merge) begin
                    if ((r_cnt_a == '0) && (r_cnt_b == '0)) begin
                        n_state = ST_EMPTY;
                    end else begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath next values and handshake outputs
    always_comb begin
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_idx_a    = r_idx_a;
        n_idx_b    = r_idx_b;
        n_ovf      = r_ovf;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;

        if (we_a) begin
            n_cnt_a = r_cnt_a + 1'b1;
        end
        if (we_b) begin
            n_cnt_b = r_cnt_b + 1'b1;
        end
        if (req_acc && ((is_load_a && !we_a) || (is_load_b && !we_b))) begin
            n_ovf = 1'b1;
        end

        if (step) begin
            if (take_a) begin
                n_idx_a = r_idx_a + 1'b1;
            end else begin
                n_idx_b = r_idx_b + 1'b1;
            end
            if (!r_pend_vld || (pick != r_pend)) begin
                n_pend     = pick;
                n_pend_vld = 1'b1;
            end
        end

        if (finish) begin
            n_cnt_a    = '0;
            n_cnt_b    = '0;
            n_idx_a    = '0;
            n_idx_b    = '0;
            n_ovf      = 1'b0;
            n_pend_vld = 1'b0;
        end

        i_req.ready      = (r_state == ST_IDLE);
        o_res.valid      = r_out_vld;
        o_res.value_res  = r_out_val;
        o_res.last       = r_out_last;
        o_res.empty_res  = r_out_empty;
        o_res.overflowed = r_out_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_idx_a    <= '0;
            r_idx_b    <= '0;
            r_ovf      <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt_a    <= n_cnt_a;
            r_cnt_b    <= n_cnt_b;
            r_idx_a    <= n_idx_a;
            r_idx_b    <= n_idx_b;
            r_ovf      <= n_ovf;
            r_pend_vld <= n_pend_vld;
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (push) begin
            r_out_val   <= (r_state == ST_EMPTY) ? '0 : r_pend;
            r_out_last  <= finish;
            r_out_empty <= (r_state == ST_EMPTY);
            r_out_ovf   <= r_ovf;
        end
    end

    `SLUM_ASSERT_NOW(a_idx_in_range, i_clk, i_rst_n, 1'b1, (r_idx_a <= r_cnt_a) && (r_idx_b <= r_cnt_b), "walk pointer passed its list count")
    `SLUM_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, (r_cnt_a <= FULL) && (r_cnt_b <= FULL), "list count exceeds depth")
    `SLUM_ASSERT_NOW(a_idle_clean, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend_vld && (r_idx_a == '0) && (r_idx_b == '0), "merge state left over in idle")
    `SLUM_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, push && finish, (r_state == ST_IDLE) && (r_cnt_a == '0) && (r_cnt_b == '0) && !r_ovf, "merge did not close after last result")
    `SLUM_ASSERT_NOW(a_empty_last, i_clk, i_rst_n, r_out_vld && r_out_empty, r_out_last, "empty result not marked last")

endmodule

### rtl/core/slum_list_ram.sv
// one list store: single write port, single registered read port
module slum_list_ram import slum_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);
    localparam int MEM_DEPTH = 1 << AW;

    logic [DATA_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### tb/sv/testbench.sv
// self-checking testbench of the sorted list union merge unit with a scoreboard and random traffic
`timescale 1ns / 1ps

module testbench;
    import slum_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;
    localparam logic signed [DW-1:0] VALUE_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] VALUE_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES = 2 * DEPTH_DEF + 8;
    localparam int ITEMS_PER_PHASE = 140;

    typedef struct packed {
        logic signed [DW-1:0] value_res;
        logic                 last;
        logic                 empty_res;
        logic                 overflowed;
    } t_union_result;

    class union_scoreboard;
        logic signed [DW-1:0] list_a[$];
        logic signed [DW-1:0] list_b[$];
        bit                   dropped_load;
        t_union_result        pending[$];
        int                   failures;

        function void note_request(logic [OP_WIDTH-1:0] op, logic signed [DW-1:0] v);
            case (op)
                OP_LOAD_A: begin
                    if (list_a.size() < DEPTH_DEF) list_a.insert(list_a.size(), v);
                    else dropped_load = 1'b1;
                end
                OP_LOAD_B: begin
                    if (list_b.size() < DEPTH_DEF) list_b.insert(list_b.size(), v);
                    else dropped_load = 1'b1;
                end
                OP_MERGE: predict_union();
                default: ;
            endcase
        endfunction

        // two-pointer walk, ties go to list a, adjacent equals dropped
        function void predict_union();
            int                   i;
            int                   j;
            bit                   emitted;
            logic signed [DW-1:0] pick;
            logic signed [DW-1:0] prev;
            t_union_result        res;
            i = 0;
            j = 0;
            emitted = 1'b0;
            prev = '0;
            if (list_a.size() == 0 && list_b.size() == 0) begin
                res = '{value_res: '0, last: 1'b1, empty_res: 1'b1,
                        overflowed: dropped_load};
                pending.insert(pending.size(), res);
            end else begin
                while (i < list_a.size() || j < list_b.size()) begin
                    if (i < list_a.size() && (j >= list_b.size() || list_a[i] <= list_b[j])) begin
                        pick = list_a[i];
                        i++;
                    end else begin
                        pick = list_b[j];
                        j++;
                    end
                    if (!emitted || pick != prev) begin
                        res = '{value_res: pick, last: 1'b0, empty_res: 1'b0,
                                overflowed: dropped_load};
                        pending.insert(pending.size(), res);
                        prev = pick;
                        emitted = 1'b1;
                    end
                end
                pending[pending.size() - 1].last = 1'b1;
            end
            list_a.delete();
            list_b.delete();
            dropped_load = 1'b0;
        endfunction

        function void compare_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic signed [DW-1:0] v, logic l, logic e, logic o);
            t_union_result want;
            if (pending.size() == 0) begin
                $error("value_res: expected no result, got 0x%0h", v);
                failures++;
                return;
            end
            want = pending.pop_front();
            compare_field("value_res", want.value_res, v);
            compare_field("last", DW'(want.last), DW'(l));
            compare_field("empty_res", DW'(want.empty_res), DW'(e));
            compare_field("overflowed", DW'(want.overflowed), DW'(o));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    slum_req_if #(.DATA_WIDTH(DW)) req_ch();
    slum_res_if #(.DATA_WIDTH(DW)) res_ch();

    sorted_list_union_merge_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    union_scoreboard sb = new();
    int src_idle_pct;
    int snk_idle_pct;
    int item_count;
    int idle_cycles;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: check accepted results, then pick ready for the next edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.value_res, res_ch.last, res_ch.empty_res,
                                res_ch.overflowed);
            res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [OP_WIDTH-1:0] op, input logic signed [DW-1:0] v);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= v;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(op, v);
        if (op != OP_UNUSED) item_count++;
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [DW-1:0] draw_element(int style);
        logic signed [DW-1:0] e;
        case (style)
            0: e = int'($urandom_range(16)) - 8;
            1: e = $urandom;
            default: e = $urandom_range(1) ? VALUE_MIN + $urandom_range(3)
                                           : VALUE_MAX - $urandom_range(3);
        endcase
        return e;
    endfunction

    function automatic int draw_length();
        if ($urandom_range(7) == 0) return $urandom_range(DEPTH_DEF + 3, DEPTH_DEF - 2);
        return $urandom_range(6);
    endfunction

    // one load sequence closed by a merge; mostly sorted lists, some noise
    task automatic send_merge_round();
        logic signed [DW-1:0] list_a[$];
        logic signed [DW-1:0] list_b[$];
        int                   kind;
        int                   style;
        int                   len_a;
        int                   len_b;
        int                   n;
        kind = $urandom_range(19);
        if (kind < 4) begin
            n = $urandom_range(8, 1);
            repeat (n) begin
                case ($urandom_range(2))
                    0: send_request(OP_LOAD_A, $urandom);
                    1: send_request(OP_LOAD_B, $urandom);
                    default: send_request(OP_UNUSED, $urandom);
                endcase
            end
        end else begin
            if (kind == 4) begin
                len_a = $urandom_range(DEPTH_DEF + 2, DEPTH_DEF);
                len_b = $urandom_range(DEPTH_DEF + 2, DEPTH_DEF);
            end else begin
                len_a = draw_length();
                len_b = draw_length();
            end
            style = $urandom_range(3);
            repeat (len_a)
                list_a.insert(list_a.size(),
                              draw_element(style == 3 ? $urandom_range(2) : style));
            repeat (len_b)
                list_b.insert(list_b.size(),
                              draw_element(style == 3 ? $urandom_range(2) : style));
            list_a.sort();
            list_b.sort();
            while (list_a.size() != 0 || list_b.size() != 0) begin
                if ($urandom_range(19) == 0)
                    send_request(OP_UNUSED, $urandom);
                if (list_b.size() == 0 || (list_a.size() != 0 && $urandom_range(1)))
                    send_request(OP_LOAD_A, list_a.pop_front());
                else
                    send_request(OP_LOAD_B, list_b.pop_front());
            end
        end
        send_request(OP_MERGE, $urandom);
    endtask

    initial begin
        int src_pct[3];
        int snk_pct[3];
        src_pct = '{36, 74, 0};
        snk_pct = '{74, 36, 0};
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_LOAD_A;
        req_ch.value = '0;
        src_idle_pct = src_pct[0];
        snk_idle_pct = snk_pct[0];
        item_count   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty union, then the unused opcode
        send_request(OP_MERGE, VALUE_MIN);
        send_request(OP_UNUSED, VALUE_MAX);
        // extremes, ties across lists, duplicates within a list
        send_request(OP_LOAD_A, VALUE_MIN);
        send_request(OP_LOAD_A, -5);
        send_request(OP_LOAD_A, 7);
        send_request(OP_LOAD_A, 7);
        send_request(OP_LOAD_B, -5);
        send_request(OP_LOAD_B, 3);
        send_request(OP_LOAD_B, VALUE_MAX);
        send_request(OP_MERGE, '0);
        // unsorted list a
        send_request(OP_LOAD_A, 9);
        send_request(OP_LOAD_A, 2);
        send_request(OP_LOAD_B, 4);
        send_request(OP_MERGE, '1);
        // only one list loaded
        send_request(OP_LOAD_B, -1);
        send_request(OP_MERGE, '0);
        send_request(OP_LOAD_A, '0);
        send_request(OP_MERGE, '0);

        for (int p = 0; p < 3; p++) begin
            src_idle_pct = src_pct[p];
            snk_idle_pct = snk_pct[p];
            while (item_count < ITEMS_PER_PHASE * (p + 1)) send_merge_round();
            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("value_res: expected %0d more results, got none", sb.pending.size());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
